// ===== sv/cces_pkg.sv =====
// Shared types, codes and calendar helper functions for the calendar clock scheduler.
package cces_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_RATE = 2'd2;

    localparam int DIV_STEPS  = 30;
    localparam int DIV25_MUL  = 41943;  // floor(2^20 / 25)
    localparam int DIV25_SHR  = 20;

    typedef enum logic [2:0] {
        KIND_FIRED  = 3'd0,
        KIND_ADDED  = 3'd1,
        KIND_REJECT = 3'd2,
        KIND_STATUS = 3'd3,
        KIND_RATE   = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REL_DIV,
        S_WALK,
        S_CHECK,
        S_TICK,
        S_FIRE,
        S_MUL,
        S_DIV,
        S_DIV_DONE,
        S_EMIT_LAST
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_REL_INIT,
        DP_REL_DIV,
        DP_WALK,
        DP_TICK,
        DP_POP,
        DP_INSERT,
        DP_RATE_SET,
        DP_MUL,
        DP_DIV,
        DP_DIV_DONE
    } dp_op_t;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  code;
    } entry_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        kind_t  kind;
        logic   last;
        logic   head_code;  // fired code from queue head, else the captured one
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       rel;
        logic       zero_rel;
        logic       abs_ok;
        logic       wm_ge12;
        logic       walk_more;
        logic       add_reject;
        logic       advance;
        logic       head_match;
        logic       div_last;
        logic       out_free;
        logic       rate_direct;
    } dp_status_t;

    function automatic logic is_leap(input logic [15:0] y);
        logic [31:0] prod;
        logic [15:0] q;
        logic [15:0] r;
        prod = 32'(y) * 32'(DIV25_MUL);
        q = 16'(prod >> DIV25_SHR);
        r = y - 16'(q * 16'd25);
        if (r >= 16'd25)
            r = r - 16'd25;
        return (y[1:0] == 2'b00) && ((r != 16'd0) || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic [15:0] y);
        logic [4:0] d;
        case (m)
            4'd2:    d = is_leap(y) ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/calendar_clock_event_scheduler.sv =====
// Top level: calendar clock with a date-ordered event queue.
// Ticks fire every queued event due on a newly reached day, then report status;
// absolute adds are checked and inserted, relative adds take one year step a cycle
// while twelve or more months remain, then one month step a cycle. Set rate is direct
// when rate is zero or countdown not positive, else via the 30-step serial divider.
// One item at a time; the next is taken once the last beat is in the output register.
// Reset (async, active low): date 17 Feb START_YR, countdown and rate zero, queue empty.
module calendar_clock_event_scheduler
    import cces_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int START_YR    = 2155
)
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         operation,
    input  logic               relative,
    input  logic [7:0]         event_month,
    input  logic [9:0]         event_day,
    input  logic [15:0]        event_year,
    input  logic [7:0]         event_code,
    input  logic [9:0]         day_seconds,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         kind,
    output logic [7:0]         fired_code,
    output logic signed [15:0] ticks_left,
    output logic [4:0]         cur_day,
    output logic [3:0]         cur_month,
    output logic [15:0]        cur_year,
    output logic               last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller: sequences tick / add / rate work and paces result beats
    cces_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: calendar state, sorted queue, date walk, divider, output register
    cces_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .START_YR    (START_YR)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .operation       (operation),
        .relative        (relative),
        .event_month     (event_month),
        .event_day       (event_day),
        .event_year      (event_year),
        .event_code      (event_code),
        .day_seconds     (day_seconds),
        .cmd             (cmd),
        .status          (status),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .kind            (kind),
        .fired_code      (fired_code),
        .ticks_left      (ticks_left),
        .cur_day         (cur_day),
        .cur_month       (cur_month),
        .cur_year        (cur_year),
        .last            (last)
    );

endmodule

// ===== sv/cces_ctrl.sv =====
// Sequencing state machine of the calendar clock scheduler.
module cces_ctrl
    import cces_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_STATUS;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_TICK: state_next = S_TICK;
                    OP_ADD:
                    begin
                        if (status.zero_rel)
                        begin
                            kind_next  = KIND_FIRED;
                            state_next = S_EMIT_LAST;
                        end
                        else if (status.rel)
                            state_next = S_REL_DIV;
                        else if (status.abs_ok)
                            state_next = S_CHECK;
                        else
                        begin
                            kind_next  = KIND_REJECT;
                            state_next = S_EMIT_LAST;
                        end
                    end
                    OP_RATE:
                    begin
                        if (status.rate_direct)
                        begin
                            kind_next  = KIND_RATE;
                            state_next = S_EMIT_LAST;
                        end
                        else
                            state_next = S_MUL;
                    end
                    default:
                    begin
                        kind_next  = KIND_STATUS;
                        state_next = S_EMIT_LAST;
                    end
                endcase
            end
            S_REL_DIV:
            begin
                if (!status.wm_ge12)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!status.walk_more)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                kind_next  = status.add_reject ? KIND_REJECT : KIND_ADDED;
                state_next = S_EMIT_LAST;
            end
            S_TICK:
            begin
                kind_next  = KIND_STATUS;
                state_next = status.advance ? S_FIRE : S_EMIT_LAST;
            end
            S_FIRE:
            begin
                if (!status.head_match)
                    state_next = S_EMIT_LAST;
            end
            S_MUL:       state_next = S_DIV;
            S_DIV:
            begin
                if (status.div_last)
                    state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                kind_next  = KIND_RATE;
                state_next = S_EMIT_LAST;
            end
            S_EMIT_LAST:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op        = DP_NOP;
        cmd.emit      = 1'b0;
        cmd.kind      = kind_reg;
        cmd.last      = 1'b0;
        cmd.head_code = 1'b0;
        item_stall    = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    cmd.op = DP_CAPTURE;
            end
            S_DECODE:
            begin
                if (status.op == OP_ADD && status.rel && !status.zero_rel)
                    cmd.op = DP_REL_INIT;
                else if (status.op == OP_RATE && status.rate_direct)
                    cmd.op = DP_RATE_SET;
            end
            S_REL_DIV:   cmd.op = DP_REL_DIV;
            S_WALK:      cmd.op = DP_WALK;
            S_CHECK:
            begin
                if (!status.add_reject)
                    cmd.op = DP_INSERT;
            end
            S_TICK:      cmd.op = DP_TICK;
            S_FIRE:
            begin
                if (status.head_match && status.out_free)
                begin
                    cmd.op        = DP_POP;
                    cmd.emit      = 1'b1;
                    cmd.kind      = KIND_FIRED;
                    cmd.head_code = 1'b1;
                end
            end
            S_MUL:       cmd.op = DP_MUL;
            S_DIV:       cmd.op = DP_DIV;
            S_DIV_DONE:  cmd.op = DP_DIV_DONE;
            S_EMIT_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                end
            end
            default:     cmd.op = DP_NOP;
        endcase
    end

endmodule

// ===== sv/cces_dp.sv =====
// Datapath: date and countdown registers, sorted event queue, date walk, divider, result register.
module cces_dp
    import cces_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int START_YR    = 2155
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         operation,
    input  logic               relative,
    input  logic [7:0]         event_month,
    input  logic [9:0]         event_day,
    input  logic [15:0]        event_year,
    input  logic [7:0]         event_code,
    input  logic [9:0]         day_seconds,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               result_stall,
    output logic               result_valid,
    output logic [2:0]         kind,
    output logic [7:0]         fired_code,
    output logic signed [15:0] ticks_left,
    output logic [4:0]         cur_day,
    output logic [3:0]         cur_month,
    output logic [15:0]        cur_year,
    output logic               last
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    // calendar and rate state
    logic [4:0]         day_reg, day_next;
    logic [3:0]         month_reg, month_next;
    logic [15:0]        year_reg, year_next;
    logic signed [15:0] cd_reg, cd_next;
    logic [15:0]        tpd_reg, tpd_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               rv_reg, rv_next;

    // captured item and working registers
    logic [1:0]  op_reg, op_next;
    logic        rel_reg, rel_next;
    logic        zero_reg, zero_next;
    logic [7:0]  code_reg, code_next;
    logic [14:0] ntpd_reg, ntpd_next;
    logic [8:0]  wm_reg, wm_next;
    logic [10:0] wd_reg, wd_next;
    logic [15:0] wy_reg, wy_next;
    logic [29:0] div_reg, div_next;
    logic [14:0] rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;

    // result beat
    logic [2:0]         kind_reg, kind_next;
    logic [7:0]         fc_reg, fc_next;
    logic signed [15:0] tl_reg, tl_next;
    logic [4:0]         od_reg, od_next;
    logic [3:0]         om_reg, om_next;
    logic [15:0]        oy_reg, oy_next;
    logic               last_reg, last_next;

    entry_t q_reg  [QUEUE_DEPTH];
    entry_t q_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt;

    logic signed [15:0] cd_dec;
    logic               advance;
    logic [4:0]         md_cur;
    logic [4:0]         md_w;
    logic [24:0]        key_w;
    logic [24:0]        key_cur;
    entry_t             new_e;
    logic [15:0]        trial;

    always_comb
    begin
        cd_dec  = (cd_reg == 16'sh8000) ? cd_reg : cd_reg - 16'sd1;
        advance = (cd_dec <= 16'sd0) && (tpd_reg != 16'd0);
        md_cur  = month_days(month_reg, year_reg);
        md_w    = month_days(wm_reg[3:0], wy_reg);
        key_w   = {wy_reg, wm_reg[3:0], wd_reg[4:0]};
        key_cur = {year_reg, month_reg, day_reg};
        new_e   = '{year: wy_reg, month: wm_reg[3:0], day: wd_reg[4:0], code: code_reg};
        trial   = {rem_reg, div_reg[29]};
    end

    // later events compare greater; they form a suffix of the queue
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            gt[i] = (CW'(i) < cnt_reg) &&
                    (key_w < {q_reg[i].year, q_reg[i].month, q_reg[i].day});
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (cmd.op == DP_POP)
            begin
                if (i < QUEUE_DEPTH - 1)
                    q_next[i] = q_reg[(i + 1) % QUEUE_DEPTH];
            end
            else if (cmd.op == DP_INSERT)
            begin
                if (i > 0 && gt[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH])
                    q_next[i] = q_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                else if ((gt[i] || CW'(i) == cnt_reg))
                    q_next[i] = new_e;
            end
        end
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        cd_next    = cd_reg;
        tpd_next   = tpd_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        rel_next   = rel_reg;
        zero_next  = zero_reg;
        code_next  = code_reg;
        ntpd_next  = ntpd_reg;
        wm_next    = wm_reg;
        wd_next    = wd_reg;
        wy_next    = wy_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        case (cmd.op)
            DP_NOP: ;
            DP_CAPTURE:
            begin
                op_next   = operation;
                rel_next  = relative;
                zero_next = relative && (event_month == 8'd0) && (event_day == 10'd0) &&
                            (event_year == 16'd0);
                code_next = event_code;
                ntpd_next = {1'b0, day_seconds, 4'b0000} + {2'b00, day_seconds, 3'b000};
                wm_next   = {1'b0, event_month};
                wd_next   = {1'b0, event_day};
                wy_next   = event_year;
            end
            DP_REL_INIT:
            begin
                wm_next = wm_reg + {5'd0, month_reg} - 9'd1;
                wd_next = wd_reg + {6'd0, day_reg};
                wy_next = wy_reg + year_reg;
            end
            DP_REL_DIV:
            begin
                if (wm_reg >= 9'd12)
                begin
                    wm_next = wm_reg - 9'd12;
                    wy_next = wy_reg + 16'd1;
                end
                else
                    wm_next = wm_reg + 9'd1;
            end
            DP_WALK:
            begin
                if (wd_reg > {6'd0, md_w})
                begin
                    wd_next = wd_reg - {6'd0, md_w};
                    if (wm_reg >= 9'd12)
                    begin
                        wm_next = 9'd1;
                        wy_next = wy_reg + 16'd1;
                    end
                    else
                        wm_next = wm_reg + 9'd1;
                end
            end
            DP_TICK:
            begin
                if (advance)
                begin
                    cd_next = signed'(tpd_reg);
                    if (day_reg >= md_cur)
                    begin
                        day_next = 5'd1;
                        if (month_reg >= 4'd12)
                        begin
                            month_next = 4'd1;
                            year_next  = year_reg + 16'd1;
                        end
                        else
                            month_next = month_reg + 4'd1;
                    end
                    else
                        day_next = day_reg + 5'd1;
                end
                else
                    cd_next = cd_dec;
            end
            DP_POP:    cnt_next = cnt_reg - CW'(1);
            DP_INSERT: cnt_next = cnt_reg + CW'(1);
            DP_RATE_SET:
            begin
                cd_next  = (tpd_reg == 16'd0) ? signed'({1'b0, ntpd_reg}) : 16'sd0;
                tpd_next = {1'b0, ntpd_reg};
            end
            DP_MUL:
            begin
                div_next  = cd_reg[14:0] * ntpd_reg;
                rem_next  = 15'd0;
                dcnt_next = 5'd0;
            end
            DP_DIV:
            begin
                if (trial >= tpd_reg)
                begin
                    rem_next = 15'(trial - tpd_reg);
                    div_next = {div_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[14:0];
                    div_next = {div_reg[28:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 5'd1;
            end
            DP_DIV_DONE:
            begin
                if (div_reg == 30'd0)
                    cd_next = 16'sd1;
                else if (div_reg > 30'd32767)
                    cd_next = 16'sd32767;
                else
                    cd_next = signed'({1'b0, div_reg[14:0]});
                tpd_next = {1'b0, ntpd_reg};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rv_next   = rv_reg;
        kind_next = kind_reg;
        fc_next   = fc_reg;
        tl_next   = tl_reg;
        od_next   = od_reg;
        om_next   = om_reg;
        oy_next   = oy_reg;
        last_next = last_reg;
        if (cmd.emit)
        begin
            rv_next   = 1'b1;
            kind_next = cmd.kind;
            if (cmd.kind == KIND_FIRED)
                fc_next = cmd.head_code ? q_reg[0].code : code_reg;
            else
                fc_next = 8'd0;
            tl_next   = cd_reg;
            od_next   = day_reg;
            om_next   = month_reg;
            oy_next   = year_reg;
            last_next = cmd.last;
        end
        else if (!result_stall)
            rv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg   <= 5'd17;
            month_reg <= 4'd2;
            year_reg  <= 16'(START_YR);
            cd_reg    <= 16'sd0;
            tpd_reg   <= 16'd0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            op_reg    <= OP_TICK;
            dcnt_reg  <= 5'd0;
        end
        else
        begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            cd_reg    <= cd_next;
            tpd_reg   <= tpd_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
            op_reg    <= op_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rel_reg  <= rel_next;
        zero_reg <= zero_next;
        code_reg <= code_next;
        ntpd_reg <= ntpd_next;
        wm_reg   <= wm_next;
        wd_reg   <= wd_next;
        wy_reg   <= wy_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        kind_reg <= kind_next;
        fc_reg   <= fc_next;
        tl_reg   <= tl_next;
        od_reg   <= od_next;
        om_reg   <= om_next;
        oy_reg   <= oy_next;
        last_reg <= last_next;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

    always_comb
    begin
        status.op          = op_reg;
        status.rel         = rel_reg;
        status.zero_rel    = zero_reg;
        status.abs_ok      = (wm_reg >= 9'd1) && (wm_reg <= 9'd12) && (wd_reg >= 11'd1) &&
                             (wd_reg <= {6'd0, md_w});
        status.wm_ge12     = (wm_reg >= 9'd12);
        status.walk_more   = (wd_reg > {6'd0, md_w});
        status.add_reject  = (key_w < key_cur) || (cnt_reg >= FULL);
        status.advance     = advance;
        status.head_match  = (cnt_reg != '0) &&
                             ({q_reg[0].year, q_reg[0].month, q_reg[0].day} == key_cur);
        status.div_last    = (dcnt_reg == 5'(DIV_STEPS - 1));
        status.out_free    = !rv_reg || !result_stall;
        status.rate_direct = (tpd_reg == 16'd0) || (cd_reg <= 16'sd0);
    end

    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign fired_code   = fc_reg;
    assign ticks_left   = tl_reg;
    assign cur_day      = od_reg;
    assign cur_month    = om_reg;
    assign cur_year     = oy_reg;
    assign last         = last_reg;

endmodule

// ===== tb/calendar_clock_event_scheduler_test.sv =====
`timescale 1ns / 1ps
// Testbench for the calendar clock event scheduler: queued stimulus, own calendar model, checker.
module calendar_clock_event_scheduler_test
    import cces_pkg::*;
;

    localparam int QDEPTH    = 16;
    localparam int YEAR0     = 2155;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic        rel;
        logic [7:0]  em;
        logic [9:0]  ed;
        logic [15:0] ey;
        logic [7:0]  code;
        logic [9:0]  spd;
    } beat_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         code;
        logic signed [15:0] left;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [15:0]        year;
        logic               last;
    } outcome_t;

    logic clk, rst_n;
    logic item_valid, item_stall;
    logic [1:0] operation;
    logic relative;
    logic [7:0] event_month;
    logic [9:0] event_day;
    logic [15:0] event_year;
    logic [7:0] event_code;
    logic [9:0] day_seconds;
    logic result_valid, result_stall;
    logic [2:0] kind;
    logic [7:0] fired_code;
    logic signed [15:0] ticks_left;
    logic [4:0] cur_day;
    logic [3:0] cur_month;
    logic [15:0] cur_year;
    logic last;

    calendar_clock_event_scheduler uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .operation(operation), .relative(relative),
        .event_month(event_month), .event_day(event_day),
        .event_year(event_year), .event_code(event_code),
        .day_seconds(day_seconds),
        .result_valid(result_valid), .result_stall(result_stall),
        .kind(kind), .fired_code(fired_code), .ticks_left(ticks_left),
        .cur_day(cur_day), .cur_month(cur_month), .cur_year(cur_year),
        .last(last)
    );

    // model of the calendar state
    int unsigned m_day, m_month, m_year, m_rate, m_count;
    int          m_cd;
    int unsigned q_day[QDEPTH], q_month[QDEPTH], q_year[QDEPTH], q_code[QDEPTH];

    beat_t    pending[$];
    outcome_t due[$];
    int       mismatches;
    int       idle_cycles;
    bit       stim_done;
    bit       drv_taken;

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y))
            return 29;
        if (m < 1 || m > 12)
            return 31;
        return lens[m - 1];
    endfunction

    function automatic bit earlier(int unsigned ay, am, ad, by, bm, bd);
        return ay < by || (ay == by && (am < bm || (am == bm && ad < bd)));
    endfunction

    function automatic void push_outcome(logic [2:0] k, int unsigned c);
        outcome_t o;
        o.kind  = k;
        o.code  = 8'(c);
        o.left  = 16'(m_cd);
        o.day   = 5'(m_day);
        o.month = 4'(m_month);
        o.year  = 16'(m_year);
        o.last  = 1'b0;
        due.push_back(o);
    endfunction

    // Returns 1 when the event went into the queue.
    function automatic bit enqueue_event(beat_t b);
        int unsigned m, d, y, pos;
        m = b.em; d = b.ed; y = b.ey;
        if (b.rel) begin
            m = m + m_month - 1;
            y = (y + m_year + m / 12) & 16'hFFFF;
            m = m % 12 + 1;
            d = d + m_day;
            while (d > days_in(m, y)) begin
                d -= days_in(m, y);
                m++;
                if (m > 12) begin
                    m = 1;
                    y = (y + 1) & 16'hFFFF;
                end
            end
        end else if (m < 1 || m > 12 || d < 1 || d > days_in(m, y))
            return 0;
        if (earlier(y, m, d, m_year, m_month, m_day) || m_count >= QDEPTH)
            return 0;
        pos = 0;
        while (pos < m_count && !earlier(y, m, d, q_year[pos], q_month[pos], q_day[pos]))
            pos++;
        for (int unsigned i = m_count; i > pos; i--) begin
            q_day[i] = q_day[i-1]; q_month[i] = q_month[i-1];
            q_year[i] = q_year[i-1]; q_code[i] = q_code[i-1];
        end
        q_day[pos] = d; q_month[pos] = m; q_year[pos] = y; q_code[pos] = b.code;
        m_count++;
        return 1;
    endfunction

    // Advance the model by one accepted beat and queue what the block should report.
    function automatic void predict_outcomes(beat_t b);
        int unsigned ntpd, qv;
        if (b.op == OP_TICK) begin
            if (m_cd > -32768)
                m_cd--;
            if (m_cd <= 0 && m_rate != 0) begin
                m_cd = m_rate;
                m_day++;
                if (m_day > days_in(m_month, m_year)) begin
                    m_day = 1;
                    m_month++;
                    if (m_month > 12) begin
                        m_month = 1;
                        m_year = (m_year + 1) & 16'hFFFF;
                    end
                end
                while (m_count > 0 && q_day[0] == m_day && q_month[0] == m_month
                       && q_year[0] == m_year) begin
                    push_outcome(KIND_FIRED, q_code[0]);
                    for (int unsigned i = 0; i + 1 < m_count; i++) begin
                        q_day[i] = q_day[i+1]; q_month[i] = q_month[i+1];
                        q_year[i] = q_year[i+1]; q_code[i] = q_code[i+1];
                    end
                    m_count--;
                end
            end
            push_outcome(KIND_STATUS, 0);
        end else if (b.op == OP_ADD) begin
            if (b.rel && b.em == 0 && b.ed == 0 && b.ey == 0)
                push_outcome(KIND_FIRED, b.code);
            else if (enqueue_event(b))
                push_outcome(KIND_ADDED, 0);
            else
                push_outcome(KIND_REJECT, 0);
        end else if (b.op == OP_RATE) begin
            ntpd = b.spd * 24;
            if (m_rate == 0)
                m_cd = ntpd;
            else if (m_cd <= 0)
                m_cd = 0;
            else begin
                qv = longint'(m_cd) * ntpd / m_rate;
                if (qv == 0) qv = 1;
                if (qv > 32767) qv = 32767;
                m_cd = qv;
            end
            m_rate = ntpd;
            push_outcome(KIND_RATE, 0);
        end else
            push_outcome(KIND_STATUS, 0);
        due[$].last = 1'b1;
    endfunction

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic beat_t make_beat(logic [1:0] op, logic rel, int unsigned m,
                                        int unsigned d, int unsigned y, int unsigned c,
                                        int unsigned s);
        beat_t b;
        b = '{op: op, rel: rel, em: 8'(m), ed: 10'(d), ey: 16'(y), code: 8'(c), spd: 10'(s)};
        return b;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stimulus: directed corners first, then mostly well-formed random traffic.
    initial
    begin
        int unsigned r;
        stim_done = 1'b0;
        // rate zero: a tick only counts down; then an unused op code with every field at maximum
        pending.push_back(make_beat(OP_TICK, 0, 0, 0, 0, 0, 0));
        pending.push_back(make_beat(2'd3, 1, 255, 1023, 65535, 255, 1023));
        // invalid absolute dates, past date, leap day check
        pending.push_back(make_beat(OP_ADD, 0, 0, 5, 2160, 1, 0));
        pending.push_back(make_beat(OP_ADD, 0, 13, 5, 2160, 2, 0));
        pending.push_back(make_beat(OP_ADD, 0, 2, 0, 2160, 3, 0));
        pending.push_back(make_beat(OP_ADD, 0, 2, 29, 2200, 4, 0));
        pending.push_back(make_beat(OP_ADD, 0, 2, 29, 2400, 5, 0));
        pending.push_back(make_beat(OP_ADD, 0, 1, 1, 2000, 6, 0));
        pending.push_back(make_beat(OP_ADD, 0, 255, 1023, 65535, 7, 0));
        // relative zero fires at once; relative extremes wrap the year
        pending.push_back(make_beat(OP_ADD, 1, 0, 0, 0, 8'hA5, 0));
        pending.push_back(make_beat(OP_ADD, 1, 255, 1023, 65535, 8'h5A, 0));
        pending.push_back(make_beat(OP_ADD, 1, 0, 1, 0, 9, 0));
        pending.push_back(make_beat(OP_ADD, 1, 0, 1, 0, 10, 0));
        pending.push_back(make_beat(OP_ADD, 1, 0, 2, 0, 11, 0));
        // rates: direct set, rescale up, to zero, max
        pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0, 1));
        pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0, 1023));
        pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0, 1));
        for (int i = 0; i < 3; i++)
            pending.push_back(make_beat(OP_TICK, 0, 0, 0, 0, 0, 0));
        pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0, 0));
        pending.push_back(make_beat(OP_TICK, 0, 0, 0, 0, 0, 0));
        pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0, 1));
        for (int i = 0; i < 188; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                pending.push_back(make_beat(OP_TICK, 0, 0, 0, 0, 0, 0));
            else if (r < 70)
                pending.push_back(make_beat(OP_ADD, 1, $urandom_range(0, 1),
                    $urandom_range(0, 40), 0, $urandom_range(0, 255), 0));
            else if (r < 76)
                pending.push_back(make_beat(OP_ADD, 0, $urandom_range(1, 12),
                    $urandom_range(1, 31), $urandom_range(2154, 2157),
                    $urandom_range(0, 255), 0));
            else if (r < 86)
                pending.push_back(make_beat(OP_RATE, 0, 0, 0, 0, 0,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                 : $urandom_range(0, 3)));
            else
                pending.push_back(make_beat(2'($urandom_range(0, 3)), 1'($urandom),
                    $urandom_range(0, 255), $urandom_range(0, 1023),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3),
                    $urandom_range(0, 255), $urandom_range(0, 1023)));
        end
        stim_done = 1'b1;
    end

    // remembers whether the beat on the bus went in at the last rising edge
    always @(posedge clk)
    begin
        drv_taken <= item_valid && !item_stall;
    end

    // Driver: presents queued beats at the falling edge, with random gaps between them.
    int unsigned drv_gap;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            drv_gap    <= 0;
        end else if (item_valid && !drv_taken) begin
            // beat held until accepted
        end else if (drv_gap != 0) begin
            item_valid <= 1'b0;
            drv_gap    <= drv_gap - 1;
        end else if (pending.size() != 0) begin
            beat_t b;
            b = pending.pop_front();
            item_valid      <= 1'b1;
            operation       <= b.op;
            relative        <= b.rel;
            event_month     <= b.em;
            event_day       <= b.ed;
            event_year      <= b.ey;
            event_code      <= b.code;
            day_seconds     <= b.spd;
            drv_gap         <= gap_len();
        end else
            item_valid <= 1'b0;
    end

    // Receiver back-pressure, same gap shape.
    int unsigned stall_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end else begin
            result_stall <= 1'b0;
            stall_left   <= gap_len();
        end
    end

    // Monitor: predicts on accepted items and checks every accepted result beat.
    always @(posedge clk)
    begin
        bit       moved;
        outcome_t got, exp_o;
        moved = 1'b0;
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                moved = 1'b1;
                predict_outcomes(beat_t'{op: operation, rel: relative, em: event_month,
                    ed: event_day, ey: event_year, code: event_code, spd: day_seconds});
            end
            if (result_valid && !result_stall) begin
                moved = 1'b1;
                got = '{kind: kind, code: fired_code, left: ticks_left, day: cur_day,
                        month: cur_month, year: cur_year, last: last};
                if (due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %p", got);
                end else begin
                    exp_o = due.pop_front();
                    if (got !== exp_o) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_o, got);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        m_day = 17; m_month = 2; m_year = YEAR0;
        m_cd = 0; m_rate = 0; m_count = 0;
        mismatches = 0;
        idle_cycles = 0;
        operation = '0; relative = 1'b0; event_month = '0; event_day = '0;
        event_year = '0; event_code = '0; day_seconds = '0;
        item_valid = 1'b0; result_stall = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // drain: everything sent, everything received, then settle
        while (!(stim_done && pending.size() == 0 && !item_valid && due.size() == 0)
               && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("calendar_clock_event_scheduler regression: fail");
            $finish;
        end else begin
            repeat (100) @(posedge clk);
            if (mismatches == 0 && due.size() == 0)
                $display("calendar_clock_event_scheduler regression: pass");
            else
                $display("calendar_clock_event_scheduler regression: fail");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
sv/cces_pkg.sv
sv/cces_ctrl.sv
sv/cces_dp.sv
sv/calendar_clock_event_scheduler.sv
tb/calendar_clock_event_scheduler_test.sv
